// File: design/stik_pkg.sv
// Shared types and constants for the stretchy two-bone IK length pipeline.
// Used by stik_dist, the top level and the property checker; depends on nothing.
package stik_pkg;

  localparam int POS_W       = 32;            // position width, signed Q16.16
  localparam int LEN_W       = 47;            // internal length width, Q31.16
  localparam int OUT_W       = 32;            // result length width
  localparam int CFG_W       = 32;            // configuration data width
  localparam int CIDX_W      = 3;             // configuration index width
  localparam int GS_W        = 32;            // global scale width, Q8.24
  localparam int GS_FRAC     = 24;
  localparam int SLIDE_W     = 16;            // slide, signed Q1.15
  localparam int SLIDE_FRAC  = 15;
  localparam int BLEND_W     = 17;            // blend amount, Q0.16 with one
  localparam int BLEND_FRAC  = 16;
  localparam int CHAIN_W     = OUT_W + 1;     // sum of two rest lengths
  localparam int ROOT_W      = POS_W + 1;     // square-root result width
  localparam int DIST_LAT    = 5 + ROOT_W + LEN_W;
  localparam int TAIL_LAT    = 8 + LEN_W;

  localparam logic [LEN_W-1:0]          LEN_CAP    = {LEN_W{1'b1}};
  localparam logic [GS_W-1:0]           GS_LOW     = 32'd1678;
  localparam logic [GS_W-1:0]           GS_FLOOR   = 32'd168;
  localparam logic [GS_W-1:0]           GS_RESET   = 32'h0100_0000;
  localparam logic signed [SLIDE_W-1:0] SLIDE_MAX  = 16'sd32735;
  localparam logic [BLEND_W-1:0]        BLEND_ONE  = 17'd65536;

  typedef logic [CIDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_UPPER   = 3'd0;
  localparam cfg_idx_t CFG_LOWER   = 3'd1;
  localparam cfg_idx_t CFG_SCALE   = 3'd2;
  localparam cfg_idx_t CFG_SLIDE   = 3'd3;
  localparam cfg_idx_t CFG_STRETCH = 3'd4;
  localparam cfg_idx_t CFG_LOCK    = 3'd5;

  // x in the lowest slot, z in the highest
  typedef logic [2:0][POS_W-1:0] point_t;

  typedef struct packed {
    logic signed [POS_W-1:0] root_x;
    logic signed [POS_W-1:0] root_y;
    logic signed [POS_W-1:0] root_z;
    logic signed [POS_W-1:0] pole_x;
    logic signed [POS_W-1:0] pole_y;
    logic signed [POS_W-1:0] pole_z;
    logic signed [POS_W-1:0] control_x;
    logic signed [POS_W-1:0] control_y;
    logic signed [POS_W-1:0] control_z;
  } stik_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] upper_length;
    logic [OUT_W-1:0] lower_length;
  } stik_out_t;

endpackage

// File: design/stik_dist.sv
// Pipelined scaled distance: |a - b| by square, sum, bit-serial root and restoring divide.
// Depends on stik_pkg; takes one point pair per enabled cycle.
module stik_dist (
  input  logic                          clk,
  input  logic                          en,
  input  logic [stik_pkg::GS_W-1:0]     gs,
  input  stik_pkg::point_t              a,
  input  stik_pkg::point_t              b,
  output logic [stik_pkg::LEN_W-1:0]    dist_len
);
  import stik_pkg::*;

  localparam int LO_W  = POS_W / 2;
  localparam int HI_W  = POS_W - LO_W;
  localparam int SQ_W  = 2 * POS_W;
  localparam int SUM_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int NUM_W = LEN_W + GS_W;
  localparam int DR_W  = GS_W + 1;

  function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] p,
                                                input logic [POS_W-1:0] q);
    logic [POS_W:0] d;
    logic [POS_W:0] m;
    d = {p[POS_W-1], p} - {q[POS_W-1], q};
    m = d[POS_W] ? (~d + 1'b1) : d;
    return m[POS_W-1:0];
  endfunction

  logic [POS_W-1:0]  mag   [3];
  logic [2*HI_W-1:0] pp_hh [3];
  logic [POS_W-1:0]  pp_hl [3];
  logic [2*LO_W-1:0] pp_ll [3];
  logic [SQ_W-1:0]   sq    [3];
  logic [SUM_W-1:0]  sum_sq;

  // magnitude, split squares, recombine, sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag[i]   <= abs_diff(a[i], b[i]);
        pp_hh[i] <= (2*HI_W)'(mag[i][POS_W-1:LO_W]) * (2*HI_W)'(mag[i][POS_W-1:LO_W]);
        pp_hl[i] <= POS_W'(mag[i][POS_W-1:LO_W]) * POS_W'(mag[i][LO_W-1:0]);
        pp_ll[i] <= (2*LO_W)'(mag[i][LO_W-1:0]) * (2*LO_W)'(mag[i][LO_W-1:0]);
        sq[i]    <= (SQ_W'(pp_hh[i]) << (2 * LO_W)) + (SQ_W'(pp_hl[i]) << (LO_W + 1))
                    + SQ_W'(pp_ll[i]);
      end
      sum_sq <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    end
  end

  // square root, one result bit per stage
  logic [REM_W-1:0]  sr_rem  [ROOT_W];
  logic [ROOT_W-1:0] sr_root [ROOT_W];
  logic [SUM_W-1:0]  sr_v    [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W-1:0]  rem_in, cur, trial;
    logic [ROOT_W-1:0] root_in;
    logic [SUM_W-1:0]  v_in;
    if (k == 0) begin : g_head
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = sum_sq;
    end else begin : g_body
      assign rem_in  = sr_rem[k-1];
      assign root_in = sr_root[k-1];
      assign v_in    = sr_v[k-1];
    end
    assign cur   = {rem_in[REM_W-3:0], v_in[SUM_W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          sr_rem[k]  <= cur - trial;
          sr_root[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          sr_rem[k]  <= cur;
          sr_root[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
        sr_v[k] <= v_in << 2;
      end
    end
  end

  // root * 2^24 / gs, saturating at LEN_CAP
  logic [NUM_W-1:0] num_ext;
  logic [DR_W-1:0]  dv0_rem;
  logic [LEN_W-1:0] dv0_low;
  logic             dv0_ovf;

  assign num_ext = NUM_W'(sr_root[ROOT_W-1]) << GS_FRAC;

  always_ff @(posedge clk) begin
    if (en) begin
      dv0_rem <= DR_W'(num_ext[NUM_W-1:LEN_W]);
      dv0_low <= num_ext[LEN_W-1:0];
      dv0_ovf <= num_ext[NUM_W-1:LEN_W] >= gs;
    end
  end

  logic [DR_W-1:0]  dv_rem [LEN_W];
  logic [LEN_W-1:0] dv_q   [LEN_W];
  logic [LEN_W-1:0] dv_low [LEN_W];
  logic             dv_ovf [LEN_W];

  for (genvar j = 0; j < LEN_W; j++) begin : g_div
    logic [DR_W-1:0]  rem_in, cur;
    logic [LEN_W-1:0] q_in, low_in;
    logic             ovf_in;
    if (j == 0) begin : g_head
      assign rem_in = dv0_rem;
      assign q_in   = '0;
      assign low_in = dv0_low;
      assign ovf_in = dv0_ovf;
    end else begin : g_body
      assign rem_in = dv_rem[j-1];
      assign q_in   = dv_q[j-1];
      assign low_in = dv_low[j-1];
      assign ovf_in = dv_ovf[j-1];
    end
    assign cur = {rem_in[GS_W-1:0], low_in[LEN_W-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= DR_W'(gs)) begin
          dv_rem[j] <= cur - DR_W'(gs);
          dv_q[j]   <= {q_in[LEN_W-2:0], 1'b1};
        end else begin
          dv_rem[j] <= cur;
          dv_q[j]   <= {q_in[LEN_W-2:0], 1'b0};
        end
        dv_low[j] <= low_in << 1;
        dv_ovf[j] <= ovf_in;
      end
    end
  end

  assign dist_len = dv_ovf[LEN_W-1] ? LEN_CAP : dv_q[LEN_W-1];

endmodule

// File: design/stretchy_two_bone_ik_lengths.sv
// Stretchy two-bone IK lengths: the distance roots and divides, then the stretch
// divide and blend, all pipelined. Throughput one transaction per cycle while the
// result is not stalled; the 47-step restoring dividers set the depth.
// A stalled result freezes every stage, so nothing is lost or repeated.
// Reset is synchronous: it clears all valid bits and restores the register defaults;
// no transaction and no configuration write is taken while rst is high.
module stretchy_two_bone_ik_lengths (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  stik_pkg::stik_in_t         item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output stik_pkg::stik_out_t        result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  stik_pkg::cfg_idx_t         cfg_index,
  input  logic [stik_pkg::CFG_W-1:0] cfg_data
);
  import stik_pkg::*;

  localparam int PIPE_LAT = DIST_LAT + TAIL_LAT;
  localparam int NUMP_W   = LEN_W + BLEND_W;        // (d - chain) * stretch
  localparam int HALF_W   = NUMP_W / 2;
  localparam int PP_W     = CHAIN_W + NUMP_W - HALF_W;
  localparam int PROD_W   = CHAIN_W + NUMP_W;
  localparam int DEN_W    = CHAIN_W + BLEND_FRAC;   // chain * 2^16
  localparam int SR_W     = DEN_W + 1;
  localparam int BL_W     = LEN_W + BLEND_W;

  // ---------------------------------------------------------------------------
  // Config registers: writes must arrive only while the pipeline is empty; unchecked.
  // ---------------------------------------------------------------------------
  logic [OUT_W-1:0]          upper_rest_length;
  logic [OUT_W-1:0]          lower_rest_length;
  logic [GS_W-1:0]           global_scale;
  logic signed [SLIDE_W-1:0] slide_amount;
  logic [BLEND_W-1:0]        stretch_amount;
  logic [BLEND_W-1:0]        pole_lock_amount;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_rest_length <= '0;
      lower_rest_length <= '0;
      global_scale      <= GS_RESET;
      slide_amount      <= '0;
      stretch_amount    <= '0;
      pole_lock_amount  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_UPPER:   upper_rest_length <= cfg_data[OUT_W-1:0];
        CFG_LOWER:   lower_rest_length <= cfg_data[OUT_W-1:0];
        CFG_SCALE:   global_scale      <= cfg_data[GS_W-1:0];
        CFG_SLIDE:   slide_amount      <= cfg_data[SLIDE_W-1:0];
        CFG_STRETCH: stretch_amount    <= cfg_data[BLEND_W-1:0];
        CFG_LOCK:    pole_lock_amount  <= cfg_data[BLEND_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Values derived from configuration, held in registers. They settle after a write,
  // long before any transaction reaches the stage that uses them.
  // ---------------------------------------------------------------------------
  logic signed [SLIDE_W-1:0]   slide_clamped, slide_negated;
  logic                        slide_neg;
  logic [SLIDE_W-2:0]          slide_abs;
  logic [OUT_W-1:0]            slide_base;
  logic [OUT_W+SLIDE_W-2:0]    slide_prod;
  logic [OUT_W-1:0]            slide_shift;
  logic                        slide_neg_q;
  logic [BLEND_W-1:0]          st_c, k_c;
  logic [BLEND_W-1:0]          st_eff, k_eff, k_inv;
  logic [GS_W-1:0]             gs_eff;
  logic [CHAIN_W-1:0]          chain;
  logic [CHAIN_W-1:0]          len_adj [2];    // slid upper and lower rest lengths
  logic [DEN_W-1:0]            den;

  always_comb begin
    if (slide_amount < -SLIDE_MAX) begin
      slide_clamped = -SLIDE_MAX;
    end else if (slide_amount > SLIDE_MAX) begin
      slide_clamped = SLIDE_MAX;
    end else begin
      slide_clamped = slide_amount;
    end
  end

  assign slide_negated = -slide_clamped;
  assign slide_neg     = slide_clamped[SLIDE_W-1];
  assign slide_abs     = slide_neg ? slide_negated[SLIDE_W-2:0] : slide_clamped[SLIDE_W-2:0];
  // negative slide takes from the upper bone, positive from the lower
  assign slide_base    = slide_neg ? upper_rest_length : lower_rest_length;
  assign slide_prod    = slide_base * slide_abs;
  assign st_c = (stretch_amount > BLEND_ONE) ? BLEND_ONE : stretch_amount;
  assign k_c  = (pole_lock_amount > BLEND_ONE) ? BLEND_ONE : pole_lock_amount;
  assign den  = {chain, {BLEND_FRAC{1'b0}}};

  always_ff @(posedge clk) begin
    slide_shift <= slide_prod[OUT_W+SLIDE_W-2:SLIDE_FRAC];
    slide_neg_q <= slide_neg;
    if (slide_neg_q) begin
      len_adj[0] <= CHAIN_W'(upper_rest_length) - CHAIN_W'(slide_shift);
      len_adj[1] <= CHAIN_W'(lower_rest_length) + CHAIN_W'(slide_shift);
    end else begin
      len_adj[0] <= CHAIN_W'(upper_rest_length) + CHAIN_W'(slide_shift);
      len_adj[1] <= CHAIN_W'(lower_rest_length) - CHAIN_W'(slide_shift);
    end
    chain  <= CHAIN_W'(upper_rest_length) + CHAIN_W'(lower_rest_length);
    gs_eff <= (global_scale < GS_LOW) ? GS_FLOOR : global_scale;
    st_eff <= st_c;
    k_eff  <= k_c;
    k_inv  <= BLEND_ONE - k_c;
  end

  // ---------------------------------------------------------------------------
  // Flow control: one valid bit per stage; a held result freezes everything.
  // ---------------------------------------------------------------------------
  logic                adv;
  logic [PIPE_LAT-1:0] vld;

  assign adv          = !(result_valid && result_stall);
  assign item_stall   = rst || !adv;
  assign result_valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LAT-2:0], item_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Three distances in lockstep: root-control, root-pole, pole-control.
  // ---------------------------------------------------------------------------
  point_t            pt_root, pt_pole, pt_ctrl;
  logic [LEN_W-1:0]  d_rc, d_rp, d_pc;

  assign pt_root = {item.root_z, item.root_y, item.root_x};
  assign pt_pole = {item.pole_z, item.pole_y, item.pole_x};
  assign pt_ctrl = {item.control_z, item.control_y, item.control_x};

  stik_dist u_dist_rc (.clk(clk), .en(adv), .gs(gs_eff), .a(pt_ctrl), .b(pt_root),
                       .dist_len(d_rc));
  stik_dist u_dist_rp (.clk(clk), .en(adv), .gs(gs_eff), .a(pt_pole), .b(pt_root),
                       .dist_len(d_rp));
  stik_dist u_dist_pc (.clk(clk), .en(adv), .gs(gs_eff), .a(pt_ctrl), .b(pt_pole),
                       .dist_len(d_pc));

  // ---------------------------------------------------------------------------
  // Stretch front end: test reach against chain, form numerator products.
  // A zero chain never stretches, so its divide result is simply dropped.
  // ---------------------------------------------------------------------------
  logic              t1_cond, t2_cond, t3_cond, t4_cond, d0_cond;
  logic [LEN_W-1:0]  t1_drp, t2_drp, t3_drp, t4_drp, d0_drp;
  logic [LEN_W-1:0]  t1_dpc, t2_dpc, t3_dpc, t4_dpc, d0_dpc;
  logic [LEN_W-1:0]  t1_diff;
  logic [NUMP_W-1:0] t2_num;
  logic [PP_W-1:0]   t3_lo [2];
  logic [PP_W-1:0]   t3_hi [2];
  logic [PROD_W-1:0] t4_prod [2];
  logic [SR_W-1:0]   d0_rem [2];
  logic [LEN_W-1:0]  d0_low [2];
  logic              d0_ovf [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_cond <= (chain != '0) && (d_rc > LEN_W'(chain));
      t1_diff <= d_rc - LEN_W'(chain);
      t1_drp  <= d_rp;
      t1_dpc  <= d_pc;

      t2_num  <= NUMP_W'(t1_diff) * NUMP_W'(st_eff);
      t2_cond <= t1_cond;
      t2_drp  <= t1_drp;
      t2_dpc  <= t1_dpc;

      // bone length times numerator, in two halves
      for (int ln = 0; ln < 2; ln++) begin
        t3_lo[ln] <= PP_W'(len_adj[ln]) * PP_W'(t2_num[HALF_W-1:0]);
        t3_hi[ln] <= PP_W'(len_adj[ln]) * PP_W'(t2_num[NUMP_W-1:HALF_W]);
        t4_prod[ln] <= PROD_W'(t3_lo[ln]) + (PROD_W'(t3_hi[ln]) << HALF_W);
        d0_rem[ln]  <= t4_prod[ln][PROD_W-1:LEN_W];
        d0_low[ln]  <= t4_prod[ln][LEN_W-1:0];
        d0_ovf[ln]  <= t4_prod[ln][PROD_W-1:LEN_W] >= SR_W'(den);
      end
      t3_cond <= t2_cond;
      t3_drp  <= t2_drp;
      t3_dpc  <= t2_dpc;
      t4_cond <= t3_cond;
      t4_drp  <= t3_drp;
      t4_dpc  <= t3_dpc;
      d0_cond <= t4_cond;
      d0_drp  <= t4_drp;
      d0_dpc  <= t4_dpc;
    end
  end

  // ---------------------------------------------------------------------------
  // Stretch dividers: product / (chain * 2^16), one quotient bit per stage,
  // with the flag and pole distances travelling alongside.
  // ---------------------------------------------------------------------------
  logic [SR_W-1:0]  sd_rem [2][LEN_W];
  logic [LEN_W-1:0] sd_q   [2][LEN_W];
  logic [LEN_W-1:0] sd_low [2][LEN_W];
  logic             sd_ovf [2][LEN_W];
  logic             sc_cond [LEN_W];
  logic [LEN_W-1:0] sc_drp  [LEN_W];
  logic [LEN_W-1:0] sc_dpc  [LEN_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_cond[0] <= d0_cond;
      sc_drp[0]  <= d0_drp;
      sc_dpc[0]  <= d0_dpc;
      for (int j = 1; j < LEN_W; j++) begin
        sc_cond[j] <= sc_cond[j-1];
        sc_drp[j]  <= sc_drp[j-1];
        sc_dpc[j]  <= sc_dpc[j-1];
      end
    end
  end

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    for (genvar j = 0; j < LEN_W; j++) begin : g_step
      logic [SR_W-1:0]  rem_in, cur;
      logic [LEN_W-1:0] q_in, low_in;
      logic             ovf_in;
      if (j == 0) begin : g_head
        assign rem_in = d0_rem[ln];
        assign q_in   = '0;
        assign low_in = d0_low[ln];
        assign ovf_in = d0_ovf[ln];
      end else begin : g_body
        assign rem_in = sd_rem[ln][j-1];
        assign q_in   = sd_q[ln][j-1];
        assign low_in = sd_low[ln][j-1];
        assign ovf_in = sd_ovf[ln][j-1];
      end
      assign cur = {rem_in[DEN_W-1:0], low_in[LEN_W-1]};
      always_ff @(posedge clk) begin
        if (adv) begin
          if (cur >= SR_W'(den)) begin
            sd_rem[ln][j] <= cur - SR_W'(den);
            sd_q[ln][j]   <= {q_in[LEN_W-2:0], 1'b1};
          end else begin
            sd_rem[ln][j] <= cur;
            sd_q[ln][j]   <= {q_in[LEN_W-2:0], 1'b0};
          end
          sd_low[ln][j] <= low_in << 1;
          sd_ovf[ln][j] <= ovf_in;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Apply stretch, blend toward pole distances, saturate into the result.
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0]   quot   [2];
  logic [LEN_W:0]     grown  [2];
  logic [LEN_W-1:0]   t5_len [2];
  logic [LEN_W-1:0]   t5_drp, t5_dpc;
  logic [BL_W-1:0]    t6_keep [2];
  logic [BL_W-1:0]    t6_pull [2];
  logic [BL_W-1:0]    mix    [2];
  logic [OUT_W-1:0]   sat    [2];

  always_comb begin
    for (int ln = 0; ln < 2; ln++) begin
      quot[ln]  = sd_ovf[ln][LEN_W-1] ? LEN_CAP : sd_q[ln][LEN_W-1];
      grown[ln] = (LEN_W+1)'(len_adj[ln]) + (LEN_W+1)'(quot[ln]);
      mix[ln]   = t6_keep[ln] + t6_pull[ln];
      if (|mix[ln][BL_W-1:BLEND_FRAC+OUT_W]) begin
        sat[ln] = {OUT_W{1'b1}};
      end else begin
        sat[ln] = mix[ln][BLEND_FRAC+OUT_W-1:BLEND_FRAC];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ln = 0; ln < 2; ln++) begin
        if (!sc_cond[LEN_W-1]) begin
          t5_len[ln] <= LEN_W'(len_adj[ln]);
        end else if (grown[ln] > {1'b0, LEN_CAP}) begin
          t5_len[ln] <= LEN_CAP;
        end else begin
          t5_len[ln] <= grown[ln][LEN_W-1:0];
        end
        t6_keep[ln] <= BL_W'(t5_len[ln]) * BL_W'(k_inv);
      end
      t5_drp     <= sc_drp[LEN_W-1];
      t5_dpc     <= sc_dpc[LEN_W-1];
      // upper bone pulls toward root-pole, lower toward pole-control
      t6_pull[0] <= BL_W'(t5_drp) * BL_W'(k_eff);
      t6_pull[1] <= BL_W'(t5_dpc) * BL_W'(k_eff);
      result.upper_length <= sat[0];
      result.lower_length <= sat[1];
    end
  end

endmodule

// File: design/stik_props.sv
// Port-level properties of the IK length pipeline, bound to the top level.
// Depends on stik_pkg for the result type.
module stik_props (
  input logic                clk,
  input logic                rst,
  input logic                item_stall,
  input logic                result_valid,
  input logic                result_stall,
  input stik_pkg::stik_out_t result
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result transaction dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("stalled result changed");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> item_stall)
    else $error("input taken while the pipeline is frozen");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled without a held result");

endmodule

bind stretchy_two_bone_ik_lengths stik_props u_stik_props (.*);

// File: bench/tb_stretchy_two_bone_ik_lengths.sv
`timescale 1ns / 100ps
// Self-checking bench for the stretchy two-bone IK length pipeline.
// Depends on stik_pkg and stretchy_two_bone_ik_lengths; predicts results in place.
module tb_stretchy_two_bone_ik_lengths;
  import stik_pkg::*;

  localparam int PIPE_LAT   = DIST_LAT + TAIL_LAT;
  localparam int QUIET_MAX  = 20000;
  localparam int RAND_ITEMS = 800;
  localparam logic [63:0] CAP64 = 64'h0000_7FFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  stik_in_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  stik_out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = CFG_UPPER;
  logic [CFG_W-1:0] cfg_data = '0;

  stretchy_two_bone_ik_lengths i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the register file, kept in step with each write
  logic [31:0] sh_upper, sh_lower, sh_scale;
  logic [15:0] sh_slide;
  logic [16:0] sh_stretch, sh_lock;

  stik_out_t lengths_due[$];
  int fails = 0;
  int quiet = 0;
  int n_items = 0;
  int n_results = 0;
  int n_writes = 0;
  bit drain_hold = 1'b0;   // long receiver hold-off requested by the stimulus
  bit calm = 1'b0;         // stretch with no random idling

  // Integer root of a 128-bit value, 64-bit result
  function automatic logic [63:0] isqrt128(logic [127:0] v);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= v) res = cand;
    end
    return res;
  endfunction

  // Quotient of a 128-bit numerator, clipped at the internal length cap
  function automatic logic [63:0] div_capped(logic [127:0] n, logic [63:0] d);
    logic [127:0] q;
    q = n / {64'd0, d};
    return (q > {64'd0, CAP64}) ? CAP64 : q[63:0];
  endfunction

  function automatic logic [63:0] span(logic [31:0] ax, ay, az, bx, by, bz,
                                       logic [63:0] gs);
    logic [127:0] acc;
    logic signed [33:0] d;
    logic [63:0] root;
    acc = '0;
    d = $signed({ax[31], ax}) - $signed({bx[31], bx});
    acc += 128'(d < 0 ? -d : d) * 128'(d < 0 ? -d : d);
    d = $signed({ay[31], ay}) - $signed({by[31], by});
    acc += 128'(d < 0 ? -d : d) * 128'(d < 0 ? -d : d);
    d = $signed({az[31], az}) - $signed({bz[31], bz});
    acc += 128'(d < 0 ? -d : d) * 128'(d < 0 ? -d : d);
    root = isqrt128(acc);
    return div_capped({64'd0, root} << 24, gs);
  endfunction

  function automatic stik_out_t predict_lengths(stik_in_t p);
    logic [63:0] u, l, c, gs, st, k, m, d, du, dl, num, qu, ql;
    int s;
    stik_out_t r;
    u = sh_upper; l = sh_lower; c = u + l;
    gs = (sh_scale < GS_LOW) ? 64'(GS_FLOOR) : 64'(sh_scale);
    st = (sh_stretch > BLEND_ONE) ? 64'd65536 : 64'(sh_stretch);
    k  = (sh_lock > BLEND_ONE) ? 64'd65536 : 64'(sh_lock);
    s = $signed(sh_slide);
    if (s < -32735) s = -32735;
    if (s > 32735) s = 32735;
    if (s < 0) begin
      m = (u * 64'(-s)) >> 15; u -= m; l += m;
    end else begin
      m = (l * 64'(s)) >> 15; u += m; l -= m;
    end
    d = span(p.control_x, p.control_y, p.control_z, p.root_x, p.root_y, p.root_z, gs);
    // zero chain skips stretch
    if (c != 0 && d > c) begin
      num = (d - c) * st;
      qu = div_capped(128'(u) * 128'(num), c << 16);
      ql = div_capped(128'(l) * 128'(num), c << 16);
      u = (u + qu > CAP64) ? CAP64 : u + qu;
      l = (l + ql > CAP64) ? CAP64 : l + ql;
    end
    if (k > 0) begin
      du = span(p.pole_x, p.pole_y, p.pole_z, p.root_x, p.root_y, p.root_z, gs);
      dl = span(p.control_x, p.control_y, p.control_z, p.pole_x, p.pole_y, p.pole_z, gs);
      u = (u * (64'd65536 - k) + du * k) >> 16;
      l = (l * (64'd65536 - k) + dl * k) >> 16;
    end
    r.upper_length = (u > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : u[31:0];
    r.lower_length = (l > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : l[31:0];
    return r;
  endfunction

  // Watchdog: count cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready) || rst)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_MAX) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_MAX);
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: stall at random, hold off for long on request
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (drain_hold) begin
      result_stall <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(99) < 14);
    end
  end

  // Checker: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    stik_out_t want;
    if (!rst && result_valid && !result_stall) begin
      n_results++;
      if (lengths_due.size() == 0) begin
        $error("result with nothing outstanding: %h", result);
        fails++;
      end else begin
        want = lengths_due.pop_front();
        if (result.upper_length !== want.upper_length) begin
          $error("upper_length: expected %h, got %h", want.upper_length,
                 result.upper_length);
          fails++;
        end
        if (result.lower_length !== want.lower_length) begin
          $error("lower_length: expected %h, got %h", want.lower_length,
                 result.lower_length);
          fails++;
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n_writes++;
    case (idx)
      CFG_UPPER:   sh_upper   = val;
      CFG_LOWER:   sh_lower   = val;
      CFG_SCALE:   sh_scale   = val;
      CFG_SLIDE:   sh_slide   = val[15:0];
      CFG_STRETCH: sh_stretch = val[16:0];
      CFG_LOCK:    sh_lock    = val[16:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one transaction, wait for acceptance; queue the prediction or the typed value.
  // Valid stays high after acceptance so transactions can follow back to back.
  task automatic push_item(stik_in_t p, bit typed, stik_out_t want);
    if (!calm) begin
      while ($urandom_range(99) < 14) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    item <= p;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    lengths_due.push_back(typed ? want : predict_lengths(p));
    n_items++;
  endtask

  // Drop valid and let the pipeline empty before touching registers
  task automatic settle();
    item_valid <= 1'b0;
    while (lengths_due.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  function automatic stik_in_t rand_item(int mode);
    stik_in_t p;
    logic [31:0] w[9];
    for (int i = 0; i < 9; i++) begin
      case (mode)
        0: w[i] = $urandom();
        1: w[i] = $signed($urandom_range(2 * 65536 * 8)) - 65536 * 8;  // near the rig
        default: w[i] = ($urandom_range(1)) ? 32'h7FFF_FFFF - $urandom_range(3)
                                            : 32'h8000_0000 + $urandom_range(3);
      endcase
    end
    p = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8]};
    return p;
  endfunction

  typedef struct {
    stik_in_t pos;
    bit typed;
    stik_out_t want;
  } row_t;

  row_t rows[$];

  initial begin
    stik_in_t p;
    row_t r;
    int burst;
    sh_upper = 0; sh_lower = 0; sh_scale = GS_RESET;
    sh_slide = 0; sh_stretch = 0; sh_lock = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. After reset everything is zero-length with no lock.
    r.typed = 1; r.want = '0;
    r.pos = '0; rows.push_back(r);
    r.pos = {9{32'h7FFF_FFFF}}; rows.push_back(r);
    r.pos = {{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}};
    rows.push_back(r);
    foreach (rows[i]) push_item(rows[i].pos, rows[i].typed, rows[i].want);
    rows.delete();
    settle();

    // Extremes of every register, with a spread of positions each time
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(CFG_UPPER, 32'h0001_0000); write_reg(CFG_LOWER, 32'h0002_0000);
                 write_reg(CFG_STRETCH, 32'd65536); end
        1: begin write_reg(CFG_SLIDE, 32'h0000_8000); write_reg(CFG_LOCK, 32'h0001_FFFF); end
        2: begin write_reg(CFG_SLIDE, 32'h0000_7FFF); write_reg(CFG_SCALE, 32'd1677); end
        3: begin write_reg(CFG_SCALE, 32'hFFFF_FFFF); write_reg(CFG_LOCK, 32'd0);
                 write_reg(CFG_STRETCH, 32'h0001_FFFF); end
        4: begin write_reg(CFG_UPPER, 32'hFFFF_FFFF); write_reg(CFG_LOWER, 32'hFFFF_FFFF);
                 write_reg(CFG_SCALE, 32'd0); end
        5: begin write_reg(CFG_UPPER, 32'd0); write_reg(CFG_LOWER, 32'd0);
                 write_reg(CFG_SCALE, 32'd1678); write_reg(CFG_LOCK, 32'd1); end
        6: begin write_reg(CFG_UPPER, 32'h0003_0000); write_reg(CFG_LOWER, 32'h0000_8000);
                 write_reg(CFG_SCALE, GS_RESET); write_reg(CFG_SLIDE, 32'h0000_C000);
                 write_reg(CFG_LOCK, 32'd32768); write_reg(CFG_STRETCH, 32'd40000); end
        default: write_reg(cfg_idx_t'(3'd7), 32'hDEAD_BEEF);  // index beyond five: ignored
      endcase
      for (int j = 0; j < 3; j++) push_item(rand_item(j), 0, '0);
      settle();
    end

    // Random part; a long hold-off on the receiver fills the pipe
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_UPPER, $urandom_range(1) ? $urandom() : $urandom_range(32'h0008_0000));
      write_reg(CFG_LOWER, $urandom_range(1) ? $urandom() : $urandom_range(32'h0008_0000));
      write_reg(CFG_SCALE, $urandom_range(3) == 0 ? $urandom() :
                           $urandom_range(32'h0400_0000, 32'h0040_0000));
      write_reg(CFG_SLIDE, $urandom());
      write_reg(CFG_STRETCH, $urandom_range(3) == 0 ? $urandom() : $urandom_range(65536));
      write_reg(CFG_LOCK, $urandom_range(3) == 0 ? $urandom() : $urandom_range(65536));
      calm = (ph == 2);
      // the held phase offers more than the pipe holds, so the input backs up
      burst = (ph == 4) ? 2 * PIPE_LAT : (RAND_ITEMS - 2 * PIPE_LAT) / 7;
      if (ph == 4) begin
        fork
          begin
            drain_hold = 1'b1;
            repeat (PIPE_LAT * 3) @(posedge clk);
            drain_hold = 1'b0;
          end
        join_none
      end
      for (int j = 0; j < burst; j++)
        push_item(rand_item($urandom_range(9) < 6 ? 1 : ($urandom_range(4) == 0 ? 2 : 0)),
                  0, '0);
      calm = 1'b0;
      settle();
    end

    $display("covered %0d transactions, %0d results, %0d register writes", n_items,
             n_results, n_writes);
    if (fails == 0 && lengths_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
